### rtl/assert_macros.svh
// Assertion macros used by the checker file of the extractor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define CHK_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/jkse_pkg.sv
// Types, constants and helper functions for the JSON key string extractor.
`default_nettype none
package jkse_pkg;

  localparam int KEY_BYTES = 8;
  localparam int KEY_W     = 8 * KEY_BYTES;
  localparam int KLEN_W    = 4;
  localparam int KPOS_W    = 4;
  localparam int SKIP_W    = 3;
  localparam int CFG_IDX_W = 4;

  localparam logic [KPOS_W-1:0] KPOS_SAT  = 4'd9;
  localparam logic [SKIP_W-1:0] HEX_DIGITS = 3'd4;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_KEY_TEXT   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 4'd1;

  // Status codes
  localparam logic [1:0] ST_FOUND      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
  localparam logic [1:0] ST_NOT_STRING = 2'd2;
  localparam logic [1:0] ST_UNTERM     = 2'd3;

  // Characters
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_QMARK = 8'h3F;

  typedef enum logic [9:0] {
    PH_SCAN        = 10'b00_0000_0001,
    PH_KEY         = 10'b00_0000_0010,
    PH_KEY_ESC     = 10'b00_0000_0100,
    PH_KEY_HEX     = 10'b00_0000_1000,
    PH_AFTER_KEY   = 10'b00_0001_0000,
    PH_AFTER_COLON = 10'b00_0010_0000,
    PH_VAL         = 10'b00_0100_0000,
    PH_VAL_ESC     = 10'b00_1000_0000,
    PH_VAL_HEX     = 10'b01_0000_0000,
    PH_DONE        = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    phase_t             phase;
    logic [SKIP_W-1:0]  escape_skip;
    logic               key_matching;
    logic [KPOS_W-1:0]  key_position;
  } scan_state_t;

  typedef struct packed {
    logic       have;
    logic [7:0] value_byte;
    logic       byte_valid;
    logic       done_res;
    logic [1:0] status;
  } result_t;

  function automatic logic is_ws(input logic [7:0] c);
    return c inside {8'h20, 8'h0A, 8'h0D, 8'h09};
  endfunction

  function automatic logic [7:0] decode_escape(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h62:   r = 8'h08;
      8'h66:   r = 8'h0C;
      8'h6E:   r = 8'h0A;
      8'h72:   r = 8'h0D;
      8'h74:   r = 8'h09;
      default: r = c;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/jkse_step.sv
// Per-byte next-state and result logic of the extractor.
`default_nettype none
module jkse_step (
  input  jkse_pkg::scan_state_t          st,
  input  logic [7:0]                     c,
  input  logic                           doc_end,
  input  logic [jkse_pkg::KEY_W-1:0]     key_text,
  input  logic [jkse_pkg::KLEN_W-1:0]    key_length,
  output jkse_pkg::scan_state_t          st_next,
  output jkse_pkg::result_t              res
);
  import jkse_pkg::*;

  logic             len_ok;
  logic             take_en;
  logic [7:0]       take_char;
  logic [7:0]       key_char;
  logic             key_hit;
  logic             have_status;
  logic             have_byte;
  logic [7:0]       vbyte;
  logic [1:0]       code;
  logic [SKIP_W-1:0] skip_dec;
  scan_state_t      nx;

  assign len_ok   = (key_length >= KLEN_W'(1)) && (key_length <= KLEN_W'(KEY_BYTES));
  assign key_char = key_text[st.key_position[2:0]*8 +: 8];
  assign skip_dec = (st.escape_skip != '0) ? st.escape_skip - SKIP_W'(1) : st.escape_skip;

  always_comb begin
    nx          = st;
    take_en     = 1'b0;
    take_char   = c;
    have_status = 1'b0;
    have_byte   = 1'b0;
    vbyte       = 8'h00;
    code        = ST_FOUND;
    case (st.phase)
      PH_SCAN: begin
        if (c == CH_QUOTE) begin
          nx.key_matching = 1'b1;
          nx.key_position = '0;
          nx.phase        = PH_KEY;
        end
      end
      PH_KEY: begin
        if (c == CH_BSL) begin
          nx.phase = PH_KEY_ESC;
        end else if (c == CH_QUOTE) begin
          nx.phase = (len_ok && st.key_matching && st.key_position == key_length) ?
                     PH_AFTER_KEY : PH_SCAN;
        end else begin
          take_en = 1'b1;
        end
      end
      PH_KEY_ESC: begin
        if (c == CH_U) begin
          nx.escape_skip = HEX_DIGITS;
          nx.phase       = PH_KEY_HEX;
        end else begin
          take_en   = 1'b1;
          take_char = decode_escape(c);
          nx.phase  = PH_KEY;
        end
      end
      PH_KEY_HEX: begin
        nx.escape_skip = skip_dec;
        if (skip_dec == '0) begin
          take_en   = 1'b1;
          take_char = CH_QMARK;
          nx.phase  = PH_KEY;
        end
      end
      PH_AFTER_KEY: begin
        if (c == CH_COLON) begin
          nx.phase = PH_AFTER_COLON;
        end else if (!is_ws(c)) begin
          // not a key after all: rescan this byte
          if (c == CH_QUOTE) begin
            nx.key_matching = 1'b1;
            nx.key_position = '0;
            nx.phase        = PH_KEY;
          end else begin
            nx.phase = PH_SCAN;
          end
        end
      end
      PH_AFTER_COLON: begin
        if (c == CH_QUOTE) begin
          nx.phase = PH_VAL;
        end else if (!is_ws(c)) begin
          have_status = 1'b1;
          code        = ST_NOT_STRING;
          nx.phase    = PH_DONE;
        end
      end
      PH_VAL: begin
        if (c == CH_BSL) begin
          nx.phase = PH_VAL_ESC;
        end else if (c == CH_QUOTE) begin
          have_status = 1'b1;
          code        = ST_FOUND;
          nx.phase    = PH_DONE;
        end else begin
          have_byte = 1'b1;
          vbyte     = c;
        end
      end
      PH_VAL_ESC: begin
        if (c == CH_U) begin
          nx.escape_skip = HEX_DIGITS;
          nx.phase       = PH_VAL_HEX;
        end else begin
          have_byte = 1'b1;
          vbyte     = decode_escape(c);
          nx.phase  = PH_VAL;
        end
      end
      PH_VAL_HEX: begin
        nx.escape_skip = skip_dec;
        if (skip_dec == '0) begin
          have_byte = 1'b1;
          vbyte     = CH_QMARK;
          nx.phase  = PH_VAL;
        end
      end
      PH_DONE: begin
      end
      default: begin
        nx.phase = PH_SCAN;
      end
    endcase

    key_hit = (st.key_position < key_length) && (st.key_position < KPOS_W'(KEY_BYTES))
              && (key_char == take_char);
    if (take_en) begin
      nx.key_matching = st.key_matching & key_hit;
      if (st.key_position < KPOS_SAT) nx.key_position = st.key_position + KPOS_W'(1);
    end

    if (doc_end) begin
      if (nx.phase != PH_DONE && !have_status) begin
        have_status = 1'b1;
        if (nx.phase == PH_AFTER_COLON) code = ST_NOT_STRING;
        else if (nx.phase == PH_VAL || nx.phase == PH_VAL_ESC || nx.phase == PH_VAL_HEX)
          code = ST_UNTERM;
        else code = ST_NOT_FOUND;
      end
      nx.phase        = PH_SCAN;
      nx.escape_skip  = '0;
      nx.key_matching = 1'b1;
      nx.key_position = '0;
    end

    st_next = nx;
    res.have       = have_status | have_byte;
    res.value_byte = have_status ? 8'h00 : vbyte;
    res.byte_valid = !have_status && have_byte;
    res.done_res   = have_status;
    res.status     = have_status ? code : ST_FOUND;
  end

endmodule
`default_nettype wire

### rtl/json_key_string_extract_unit.sv
// Bytes and results are both registered; the scan state is one register updated per byte.
// Throughput: one document byte per cycle while the output is not stalled.
// A stalled output holds the staged byte, and the input accepts nothing more
// until the waiting result is taken.
// Reset: synchronous; clears both valid flags and the scan state, restores the key registers.
`default_nettype none
module json_key_string_extract_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      doc_byte,
  input  logic                            doc_end,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      value_byte,
  output logic                            byte_valid,
  output logic                            done_res,
  output logic [1:0]                      status,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [jkse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jkse_pkg::KEY_W-1:0]      cfg_data
);
  import jkse_pkg::*;

  logic                s1_valid;
  logic [7:0]          s1_byte;
  logic                s1_end;
  logic                advance;
  logic [KEY_W-1:0]    key_text;
  logic [KLEN_W-1:0]   key_length;
  scan_state_t         scan;
  scan_state_t         scan_next;
  result_t             res;

  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;
  assign cfg_ready = 1'b1;

  jkse_step u_step (
    .st         (scan),
    .c          (s1_byte),
    .doc_end    (s1_end),
    .key_text   (key_text),
    .key_length (key_length),
    .st_next    (scan_next),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      key_text   <= '0;
      key_length <= KLEN_W'(1);
    end else if (cfg_valid) begin
      if (cfg_index == REG_KEY_TEXT) key_text <= cfg_data;
      else if (cfg_index == REG_KEY_LENGTH) key_length <= cfg_data[KLEN_W-1:0];
    end
  end

  // Stage the incoming byte
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= (in_valid && in_ready) || (s1_valid && !advance);
    end
    if (in_valid && in_ready) begin
      s1_byte <= doc_byte;
      s1_end  <= doc_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan.phase        <= PH_SCAN;
      scan.escape_skip  <= '0;
      scan.key_matching <= 1'b1;
      scan.key_position <= '0;
    end else if (advance) begin
      scan <= scan_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.have) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance && res.have) begin
      value_byte <= res.value_byte;
      byte_valid <= res.byte_valid;
      done_res   <= res.done_res;
      status     <= res.status;
    end
  end

endmodule
`default_nettype wire

### rtl/jkse_checker.sv
// Port-level checker for the extractor, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module jkse_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [7:0]                      value_byte,
  input  logic                            byte_valid,
  input  logic                            done_res,
  input  logic [1:0]                      status
);
  import jkse_pkg::*;

  // A result carries either a value byte or the status, never both
  `CHK_ASSERT(a_one_kind, clk, rst, out_valid |-> (byte_valid ^ done_res), "result kind not unique")
  `CHK_ASSERT(a_byte_clean, clk, rst, (out_valid && byte_valid) |-> (status == ST_FOUND), "status set in value byte")
  `CHK_ASSERT(a_status_clean, clk, rst, (out_valid && done_res) |-> (value_byte == 8'h00), "value byte set in status")
  `CHK_ASSERT(a_out_hold, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(value_byte) && $stable(status)), "stalled result changed")
  `CHK_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "result valid after reset")

endmodule

bind json_key_string_extract_unit jkse_checker u_jkse_checker (.*);
`default_nettype wire
